// ===== rtl/vatgd_pkg.sv =====
package vatgd_pkg;

    // cordic and square root depth
    localparam int ITERS = 30;
    localparam int SQRT_STEPS = 32;

    // register map
    localparam logic [1:0] ADDR_RADIUS = 2'd0;

    // fixed constants
    localparam logic [13:0] RADIUS_RESET = 14'd6371;
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [22:0] ANGLE_MAX = 23'd5898240;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    // atan(2^-i) in q30
    localparam logic [29:0] ATAN_TAB [0:ITERS-1] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
        30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
        30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
        30'd32, 30'd16, 30'd8, 30'd4, 30'd2
    };

    typedef struct packed {
        logic signed [23:0] view_angle;
        logic        [20:0] sensor_altitude;
    } t_in;

    typedef struct packed {
        logic signed [23:0] ground_distance;
        logic               misses_surface;
    } t_out;

    // side data carried along the sine pipeline
    typedef struct packed {
        logic [20:0] alt;
        logic        neg;
        logic [30:0] theta;
    } t_sin_tag;

    // side data carried along the square root pipeline
    typedef struct packed {
        logic        miss;
        logic [31:0] y16;
        logic        neg;
        logic [30:0] theta;
    } t_sq_tag;

    // side data carried along the vectoring pipeline
    typedef struct packed {
        logic        miss;
        logic        neg;
        logic [30:0] theta;
    } t_vec_tag;

endpackage

// ===== rtl/view_angle_to_ground_distance.sv =====
// View angle to ground distance on a spherical planet.
// Input channel: i_valid / o_ready carry one beat of i_data (signed view angle
// in degrees Q8.16, sensor altitude in km Q.10). Output channel: o_valid /
// i_ready carry one beat of o_data (signed ground distance in km Q.10, and a
// miss flag with the distance forced to zero when the line of sight misses).
// The planet radius in whole km sits in an APB register at address 0.
// From an accepted input beat to its output beat the pipeline holds
// one angle scaling stage, 30 sine cordic stages, three stages for the
// product, the squares and the discriminant, 32 square root stages,
// 30 vectoring cordic stages, and two stages for the scaling and saturation.
// Throughput is one beat per cycle unless the output stalls; every stage holds one item.
// Reset clears all valid bits and sets the radius to 6371 km.
// When the receiver stalls with a beat waiting in the output register the
// whole pipeline holds, o_ready drops, and nothing is lost or repeated;
// a bubble-free flow resumes the cycle i_ready returns.
// The radius must be written only while the pipeline is empty; the block does not enforce it.
module view_angle_to_ground_distance
    import vatgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        en;
    logic [13:0] r_radius;

    // pipeline advances unless a result is stuck at the output
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (psel && penable && pwrite && paddr == ADDR_RADIUS) begin
            r_radius <= pwdata[13:0];
        end
    end

    assign prdata = (paddr == ADDR_RADIUS) ? {18'b0, r_radius} : 32'b0;
    assign pready = 1'b1;

    // angle magnitude, clamp and conversion to q30 radians
    logic        n_neg;
    logic [23:0] n_abs;
    logic [22:0] n_mag;
    logic [47:0] n_prod0;
    logic        r_s0_vld;
    t_sin_tag    r_s0_tag;

    always_comb begin
        n_neg = i_data.view_angle[23];
        n_abs = n_neg ? 24'(-i_data.view_angle) : i_data.view_angle;
        n_mag = (n_abs > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : n_abs[22:0];
        n_prod0 = 48'(n_mag) * 48'(DEG_TO_RAD_Q30) + 48'd32768;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_tag.alt <= i_data.sensor_altitude;
            r_s0_tag.neg <= n_neg;
            r_s0_tag.theta <= n_prod0[46:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    // sine of the angle
    logic        sin_vld;
    logic [30:0] sin_val;
    t_sin_tag    sin_tag;

    vatgd_sin u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s0_vld),
        .i_tag   (r_s0_tag),
        .o_vld   (sin_vld),
        .o_sin   (sin_val),
        .o_tag   (sin_tag)
    );

    // perpendicular offset y = (R + h) * sin
    logic [24:0] n_h10;
    logic [55:0] n_prod1;
    logic        r_s1_vld;
    logic [31:0] r_s1_y16;
    logic        r_s1_neg;
    logic [30:0] r_s1_theta;

    always_comb begin
        n_h10 = {1'b0, r_radius, 10'b0} + 25'(sin_tag.alt);
        n_prod1 = 56'(n_h10) * 56'(sin_val) + 56'd8388608;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_y16 <= n_prod1[55:24];
            r_s1_neg <= sin_tag.neg;
            r_s1_theta <= sin_tag.theta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= sin_vld;
        end
    end

    // squares of the radius and of y, both in q32
    logic        r_s2_vld;
    logic [59:0] r_s2_rsq;
    logic [63:0] r_s2_ysq;
    logic [31:0] r_s2_y16;
    logic        r_s2_neg;
    logic [30:0] r_s2_theta;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_rsq <= {28'(r_radius) * 28'(r_radius), 32'b0};
            r_s2_ysq <= 64'(r_s1_y16) * 64'(r_s1_y16);
            r_s2_y16 <= r_s1_y16;
            r_s2_neg <= r_s1_neg;
            r_s2_theta <= r_s1_theta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    // discriminant and miss test
    logic [64:0] n_diff;
    logic        r_s3_vld;
    logic [59:0] r_s3_disc;
    t_sq_tag     r_s3_tag;

    assign n_diff = {5'b0, r_s2_rsq} - {1'b0, r_s2_ysq};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_disc <= n_diff[64] ? 60'd0 : n_diff[59:0];
            r_s3_tag.miss <= n_diff[64];
            r_s3_tag.y16 <= r_s2_y16;
            r_s3_tag.neg <= r_s2_neg;
            r_s3_tag.theta <= r_s2_theta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    // x = sqrt(discriminant)
    logic        sq_vld;
    logic [30:0] sq_root;
    t_sq_tag     sq_tag;

    vatgd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s3_vld),
        .i_rad   (r_s3_disc),
        .i_tag   (r_s3_tag),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    // angle of (x, y)
    t_vec_tag           vec_in_tag;
    logic               vec_vld;
    logic signed [32:0] vec_ang;
    t_vec_tag           vec_tag;

    assign vec_in_tag.miss = sq_tag.miss;
    assign vec_in_tag.neg = sq_tag.neg;
    assign vec_in_tag.theta = sq_tag.theta;

    vatgd_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_x     (sq_root),
        .i_y     (sq_tag.y16),
        .i_tag   (vec_in_tag),
        .o_vld   (vec_vld),
        .o_ang   (vec_ang),
        .o_tag   (vec_tag)
    );

    // central angle times radius
    logic signed [33:0] n_fi;
    logic [30:0]        n_fi_pos;
    logic               r_s4_vld;
    logic [44:0]        r_s4_prod;
    logic               r_s4_neg;
    logic               r_s4_miss;

    always_comb begin
        n_fi = 34'(vec_ang) - $signed({3'b0, vec_tag.theta});
        n_fi_pos = n_fi[33] ? 31'd0 : n_fi[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_prod <= 45'(r_radius) * 45'(n_fi_pos);
            r_s4_neg <= vec_tag.neg;
            r_s4_miss <= vec_tag.miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= vec_vld;
        end
    end

    // rounding, sign, saturation and output register
    logic [44:0]        n_rnd;
    logic [24:0]        n_dist;
    logic signed [23:0] n_gd;
    logic               r_out_vld;
    t_out               r_out;

    always_comb begin
        n_rnd = r_s4_prod + 45'd524288;
        n_dist = n_rnd[44:20];
        if (r_s4_miss) begin
            n_gd = '0;
        end else if (r_s4_neg) begin
            n_gd = (n_dist > 25'd8388608) ? 24'sh800000 : 24'(-n_dist);
        end else begin
            n_gd = (n_dist > 25'd8388607) ? 24'sh7FFFFF : n_dist[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.ground_distance <= n_gd;
            r_out.misses_surface <= r_s4_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_s4_vld;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data = r_out;

endmodule

// ===== rtl/vatgd_sin.sv =====
module vatgd_sin
    import vatgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  t_sin_tag    i_tag,
    output logic        o_vld,
    output logic [30:0] o_sin,
    output t_sin_tag    o_tag
);

    logic signed [33:0] w_x [0:ITERS];
    logic signed [33:0] w_y [0:ITERS];
    logic signed [32:0] w_z [0:ITERS];
    logic               w_v [0:ITERS];
    t_sin_tag           w_t [0:ITERS];

    logic signed [33:0] r_x [0:ITERS-1];
    logic signed [33:0] r_y [0:ITERS-1];
    logic signed [32:0] r_z [0:ITERS-1];
    logic               r_vld [0:ITERS-1];
    t_sin_tag           r_tag [0:ITERS-1];

    // rotation starts from the inverse gain on the x axis
    assign w_x[0] = $signed({4'b0, INV_GAIN_Q30});
    assign w_y[0] = '0;
    assign w_z[0] = $signed({2'b0, i_tag.theta});
    assign w_v[0] = i_vld;
    assign w_t[0] = i_tag;

    genvar k;
    for (k = 0; k < ITERS; k++) begin : g_stage
        logic signed [33:0] xs;
        logic signed [33:0] ys;
        logic signed [32:0] at;
        assign xs = w_x[k] >>> k;
        assign ys = w_y[k] >>> k;
        assign at = $signed({3'b0, ATAN_TAB[k]});

        // one micro-rotation per stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[k][32]) begin
                    r_x[k] <= w_x[k] - ys;
                    r_y[k] <= w_y[k] + xs;
                    r_z[k] <= w_z[k] - at;
                end else begin
                    r_x[k] <= w_x[k] + ys;
                    r_y[k] <= w_y[k] - xs;
                    r_z[k] <= w_z[k] + at;
                end
                r_tag[k] <= w_t[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v[k];
            end
        end

        assign w_x[k+1] = r_x[k];
        assign w_y[k+1] = r_y[k];
        assign w_z[k+1] = r_z[k];
        assign w_v[k+1] = r_vld[k];
        assign w_t[k+1] = r_tag[k];
    end

    // clamp the sine to [0, 1]
    always_comb begin
        if (w_y[ITERS][33]) begin
            o_sin = '0;
        end else if (w_y[ITERS] > $signed({3'b0, ONE_Q30})) begin
            o_sin = ONE_Q30;
        end else begin
            o_sin = w_y[ITERS][30:0];
        end
    end

    assign o_vld = w_v[ITERS];
    assign o_tag = w_t[ITERS];

endmodule

// ===== rtl/vatgd_isqrt.sv =====
module vatgd_isqrt
    import vatgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [59:0] i_rad,
    input  t_sq_tag     i_tag,
    output logic        o_vld,
    output logic [30:0] o_root,
    output t_sq_tag     o_tag
);

    logic [63:0] w_v [0:SQRT_STEPS];
    logic [63:0] w_r [0:SQRT_STEPS];
    logic        w_vl [0:SQRT_STEPS];
    t_sq_tag     w_t [0:SQRT_STEPS];

    logic [63:0] r_v [0:SQRT_STEPS-1];
    logic [63:0] r_r [0:SQRT_STEPS-1];
    logic        r_vld [0:SQRT_STEPS-1];
    t_sq_tag     r_tag [0:SQRT_STEPS-1];

    assign w_v[0] = {4'b0, i_rad};
    assign w_r[0] = '0;
    assign w_vl[0] = i_vld;
    assign w_t[0] = i_tag;

    genvar k;
    for (k = 0; k < SQRT_STEPS; k++) begin : g_stage
        logic [63:0] bitv;
        logic [63:0] trial;
        assign bitv = 64'd1 << (62 - 2 * k);
        assign trial = w_r[k] + bitv;

        // one result bit per stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_v[k] >= trial) begin
                    r_v[k] <= w_v[k] - trial;
                    r_r[k] <= (w_r[k] >> 1) + bitv;
                end else begin
                    r_v[k] <= w_v[k];
                    r_r[k] <= w_r[k] >> 1;
                end
                r_tag[k] <= w_t[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vl[k];
            end
        end

        assign w_v[k+1] = r_v[k];
        assign w_r[k+1] = r_r[k];
        assign w_vl[k+1] = r_vld[k];
        assign w_t[k+1] = r_tag[k];
    end

    assign o_vld = w_vl[SQRT_STEPS];
    assign o_root = w_r[SQRT_STEPS][30:0];
    assign o_tag = w_t[SQRT_STEPS];

endmodule

// ===== rtl/vatgd_vec.sv =====
module vatgd_vec
    import vatgd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [30:0]        i_x,
    input  logic [31:0]        i_y,
    input  t_vec_tag           i_tag,
    output logic               o_vld,
    output logic signed [32:0] o_ang,
    output t_vec_tag           o_tag
);

    logic signed [35:0] w_x [0:ITERS];
    logic signed [35:0] w_y [0:ITERS];
    logic signed [32:0] w_z [0:ITERS];
    logic               w_v [0:ITERS];
    t_vec_tag           w_t [0:ITERS];

    logic signed [35:0] r_x [0:ITERS-1];
    logic signed [35:0] r_y [0:ITERS-1];
    logic signed [32:0] r_z [0:ITERS-1];
    logic               r_vld [0:ITERS-1];
    t_vec_tag           r_tag [0:ITERS-1];

    assign w_x[0] = $signed({5'b0, i_x});
    assign w_y[0] = $signed({4'b0, i_y});
    assign w_z[0] = '0;
    assign w_v[0] = i_vld;
    assign w_t[0] = i_tag;

    genvar k;
    for (k = 0; k < ITERS; k++) begin : g_stage
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        logic signed [32:0] at;
        assign xs = w_x[k] >>> k;
        assign ys = w_y[k] >>> k;
        assign at = $signed({3'b0, ATAN_TAB[k]});

        // drive y toward zero, one step per stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_y[k] > 36'sd0) begin
                    r_x[k] <= w_x[k] + ys;
                    r_y[k] <= w_y[k] - xs;
                    r_z[k] <= w_z[k] + at;
                end else begin
                    r_x[k] <= w_x[k] - ys;
                    r_y[k] <= w_y[k] + xs;
                    r_z[k] <= w_z[k] - at;
                end
                r_tag[k] <= w_t[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v[k];
            end
        end

        assign w_x[k+1] = r_x[k];
        assign w_y[k+1] = r_y[k];
        assign w_z[k+1] = r_z[k];
        assign w_v[k+1] = r_vld[k];
        assign w_t[k+1] = r_tag[k];
    end

    assign o_vld = w_v[ITERS];
    assign o_ang = w_z[ITERS];
    assign o_tag = w_t[ITERS];

endmodule
